// ===== rtl/core/rlm_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rlm_pkg
// Shared types and constants for the RMS level meter.
// ============================================================================
package rlm_pkg;

    localparam int MAX_FRAME   = 1024;
    localparam int SAMPLE_BITS = 16;

    localparam int RMS_W   = 16;
    localparam int COUNT_W = 11;
    localparam int MAG_W   = SAMPLE_BITS;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = 41;
    localparam int MEAN_W  = 32;

    localparam int DIV_STEPS  = SUM_W;
    localparam int SQRT_STEPS = MEAN_W / 2;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } rlm_in_t;

    typedef struct packed {
        logic [RMS_W-1:0]   rms;
        logic [COUNT_W-1:0] sample_count;
        logic               overflow;
    } rlm_out_t;

    typedef struct packed {
        logic [SUM_W-1:0]   square_sum;
        logic [COUNT_W-1:0] count;
        logic               overflow;
    } rlm_frame_t;

endpackage

// ===== rtl/core/rms_level_meter_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rms_level_meter_unit
// Frame RMS level meter: sums sample squares, then floor(sqrt(sum / count)).
// ============================================================================
//  channel   dir   payload      handshake
//  s_*       in    rlm_in_t     s_valid / s_ready, one sample per beat
//  m_*       out   rlm_out_t    m_valid / m_ready, one result per frame
//
//  Samples are taken one per cycle while s_ready is high; a beat with last set
//  hands the frame to a two-entry queue. The back part then divides the sum by
//  the count, takes the root and hands the result to the output register.
//  s_ready drops only while the queue holds two frames; m_ready low holds
//  the result register and then the back part. Reset clears all control.
// ============================================================================
module rms_level_meter_unit
    import rlm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  rlm_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output rlm_out_t m_data
);

    logic       push_valid;
    logic       push_ready;
    rlm_frame_t push_data;
    logic       pop_valid;
    logic       pop_ready;
    rlm_frame_t pop_data;

    rlm_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    rlm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    rlm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== rtl/core/rlm_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rlm_front
// Squares and accumulates samples; hands off a closed frame on the last beat.
// ============================================================================
module rlm_front
    import rlm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  rlm_in_t    s_data,
    output logic       push_valid,
    input  logic       push_ready,
    output rlm_frame_t push_data
);

    logic [SUM_W-1:0]   sum_reg,   sum_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               ovf_reg,   ovf_next;

    logic               accept;
    logic               full;
    logic [MAG_W-1:0]   raw;
    logic [MAG_W-1:0]   mag;
    logic [SQ_W-1:0]    sq;
    logic [SUM_W-1:0]   acc_sum;
    logic [COUNT_W-1:0] acc_count;
    logic               acc_ovf;

    assign s_ready = push_ready;
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == COUNT_W'(MAX_FRAME));

    assign raw = s_data.sample[MAG_W-1:0];
    assign mag = raw[MAG_W-1] ? (~raw + MAG_W'(1)) : raw;
    assign sq  = mag * mag;

    always_comb begin
        if (full) begin
            acc_sum   = sum_reg;
            acc_count = count_reg;
            acc_ovf   = 1'b1;
        end else begin
            acc_sum   = sum_reg + SUM_W'(sq);
            acc_count = count_reg + COUNT_W'(1);
            acc_ovf   = ovf_reg;
        end
    end

    assign push_valid           = accept && s_data.last;
    assign push_data.square_sum = acc_sum;
    assign push_data.count      = acc_count;
    assign push_data.overflow   = acc_ovf;

    always_comb begin
        sum_next   = sum_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (accept) begin
            if (s_data.last) begin
                sum_next   = '0;
                count_next = '0;
                ovf_next   = 1'b0;
            end else begin
                sum_next   = acc_sum;
                count_next = acc_count;
                ovf_next   = acc_ovf;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

// ===== rtl/core/rlm_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rlm_queue
// Two-entry queue of closed frames between front and back.
// ============================================================================
module rlm_queue
    import rlm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push_valid,
    output logic       push_ready,
    input  rlm_frame_t push_data,
    output logic       pop_valid,
    input  logic       pop_ready,
    output rlm_frame_t pop_data
);

    rlm_frame_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg,   fill_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== rtl/core/rlm_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rlm_back
// Per frame: restoring divide of the sum by the count, then a bitwise
// integer square root; the result goes to the output register.
// ============================================================================
module rlm_back
    import rlm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  rlm_frame_t pop_data,
    output logic       m_valid,
    input  logic       m_ready,
    output rlm_out_t   m_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SQRT = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [STEP_W-1:0]  step_reg,  step_next;
    logic [SUM_W-1:0]   dvd_reg,   dvd_next;
    logic [COUNT_W-1:0] rem_reg,   rem_next;
    logic [COUNT_W-1:0] cnt_reg,   cnt_next;
    logic               ovf_reg,   ovf_next;
    logic [MEAN_W-1:0]  v_reg,     v_next;
    logic [MEAN_W-1:0]  root_reg,  root_next;
    logic [MEAN_W-1:0]  bit_reg,   bit_next;
    logic               mvalid_reg, mvalid_next;
    rlm_out_t           mdata_reg,  mdata_next;

    logic [COUNT_W:0]   trial_rem;
    logic               rem_ge;
    logic [MEAN_W-1:0]  trial_root;
    logic               root_ge;
    logic               out_free;

    assign trial_rem  = {rem_reg, dvd_reg[SUM_W-1]};
    assign rem_ge     = (trial_rem >= {1'b0, cnt_reg});
    assign trial_root = root_reg + bit_reg;
    assign root_ge    = (v_reg >= trial_root);
    assign out_free   = !mvalid_reg || m_ready;

    assign pop_ready = (state_reg == ST_IDLE);
    assign m_valid   = mvalid_reg;
    assign m_data    = mdata_reg;

    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        v_next      = v_reg;
        root_next   = root_reg;
        bit_next    = bit_reg;
        mvalid_next = mvalid_reg && !m_ready;
        mdata_next  = mdata_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    dvd_next   = pop_data.square_sum;
                    cnt_next   = pop_data.count;
                    ovf_next   = pop_data.overflow;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (rem_ge) begin
                    rem_next = COUNT_W'(trial_rem - {1'b0, cnt_reg});
                end else begin
                    rem_next = trial_rem[COUNT_W-1:0];
                end
                dvd_next  = {dvd_reg[SUM_W-2:0], rem_ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    step_next  = '0;
                    state_next = ST_SQRT;
                    root_next  = '0;
                    bit_next   = MEAN_W'(1) << (MEAN_W - 2);
                    if (cnt_reg == '0) begin
                        v_next = '0;
                    end else begin
                        v_next = dvd_next[MEAN_W-1:0];
                    end
                end
            end
            ST_SQRT: begin
                if (root_ge) begin
                    v_next    = v_reg - trial_root;
                    root_next = (root_reg >> 1) + bit_reg;
                end else begin
                    root_next = root_reg >> 1;
                end
                bit_next  = bit_reg >> 2;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SQRT_STEPS - 1)) begin
                    step_next  = '0;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    mvalid_next             = 1'b1;
                    mdata_next.rms          = root_reg[RMS_W-1:0];
                    mdata_next.sample_count = cnt_reg;
                    mdata_next.overflow     = ovf_reg;
                    state_next              = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        ovf_reg   <= ovf_next;
        v_reg     <= v_next;
        root_reg  <= root_next;
        bit_reg   <= bit_next;
        mdata_reg <= mdata_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule
